FILE: sv/bpcb_pkg.sv
// Package for the button press classifier and LED blinker.
// Holds request and press codes, register indexes, reset values and the
// blink timing helpers. No dependencies.
package bpcb_pkg;

   // Request codes carried on req_tuser
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_BUTTON = 2'd1;
   localparam logic [1:0] REQ_PROBE  = 2'd2;

   // Press kind codes
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_SHORT = 2'd1;
   localparam logic [1:0] KIND_LONG  = 2'd2;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_ON     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLASH_PERIOD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_BLINKS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_BLINKS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_BLINKS = 3'd6;
   localparam int CSR_DATA_W = 16;

   // Reset values
   localparam logic [15:0] RST_DEBOUNCE     = 16'd10;
   localparam logic [15:0] RST_LONG_PRESS   = 16'd500;
   localparam logic [7:0]  RST_FLASH_ON     = 8'd2;
   localparam logic [7:0]  RST_FLASH_PERIOD = 8'd20;
   localparam logic [3:0]  RST_SHORT_BLINKS = 4'd2;
   localparam logic [3:0]  RST_LONG_BLINKS  = 4'd5;
   localparam logic [3:0]  RST_PROBE_BLINKS = 4'd10;

   // Longest burst: 256 * 14 + 255 fits in 12 bits
   localparam int SPAN_W = 12;

   function automatic logic [7:0] on_time(input logic [7:0] flash_on);
      on_time = (flash_on == 8'd0) ? 8'd1 : flash_on;
   endfunction

   function automatic logic [7:0] off_time(input logic [7:0] flash_on,
                                           input logic [7:0] period);
      logic [7:0] on;
      on = on_time(flash_on);
      off_time = (period > on) ? (period - on) : 8'd1;
   endfunction

   // Offset from burst start to burst end: cycle * (blinks - 1) + on time
   function automatic logic [SPAN_W-1:0] burst_span(input logic [7:0] flash_on,
                                                    input logic [7:0] period,
                                                    input logic [3:0] blinks);
      logic [8:0]  cycle;
      logic [3:0]  n;
      logic [12:0] prod;
      cycle = {1'b0, on_time(flash_on)} + {1'b0, off_time(flash_on, period)};
      n = (blinks == 4'd0) ? 4'd1 : blinks;
      prod = 13'(cycle) * 13'(n - 4'd1) + 13'(on_time(flash_on));
      burst_span = prod[SPAN_W-1:0];
   endfunction

endpackage

FILE: sv/button_press_classifier_blinker.sv
// Top level of the button press classifier and LED blinker.
// Depends on bpcb_pkg.
//
// Usage:
//   req_*  : stream of events. req_tuser is the event code (tick, button
//            level change, probe falling edge), req_tdata[0] the button pin
//            level (0 pressed). One transfer per event.
//   rsp_*  : one result per accepted event, holding LED state, press kind
//            and counter-running flag after that event.
//   csr_*  : register writes (index, data), always ready; write only while
//            no event is outstanding.
// The result is registered and appears in the cycle after its event is
// taken. One event per cycle is sustained while results are taken; the
// whole state update is a single combinational step from the state
// registers into the result register. When the receiver stalls, the result
// register holds and req_tready drops until the result is taken; it stays
// high while the result is consumed in the same cycle. Reset clears the
// counter, burst state and result valid, and loads the register defaults.
module button_press_classifier_blinker #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [0] button_level
   input  logic [1:0]                           req_tuser,  // [1:0] req_type
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] led_on, [2:1] press_kind, [3] busy_res, [7:4] zero
   output logic [7:0]                           rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bpcb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bpcb_pkg::CSR_DATA_W-1:0]      csr_data
);
   import bpcb_pkg::*;

   localparam int CW    = COUNT_WIDTH;
   localparam int CMP_W = (CW > 16) ? CW : 16;

   // Registers
   logic [15:0] debounce_ff, long_press_ff;
   logic [7:0]  flash_on_ff, flash_period_ff;
   logic [3:0]  short_blinks_ff, long_blinks_ff, probe_blinks_ff;

   // State
   logic [CW-1:0] tc_ff, tc_in;
   logic          run_ff, run_in;
   logic          armed_ff, armed_in;
   logic          active_ff, active_in;
   logic [CW-1:0] phase_ff, phase_in;
   logic [CW-1:0] end_ff, end_in;
   logic          led_ff, led_in;
   logic [1:0]    kind_in;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_data_ff;

   logic          req_fire;
   logic          pressed;
   logic          start;
   logic [3:0]    blinks;
   logic [CW-1:0] tc_inc;
   logic [7:0]    on_t, off_t;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pressed = !req_tdata[0];
   assign tc_inc  = tc_ff + CW'(1);
   assign on_t    = on_time(flash_on_ff);
   assign off_t   = off_time(flash_on_ff, flash_period_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= RST_DEBOUNCE;
         long_press_ff   <= RST_LONG_PRESS;
         flash_on_ff     <= RST_FLASH_ON;
         flash_period_ff <= RST_FLASH_PERIOD;
         short_blinks_ff <= RST_SHORT_BLINKS;
         long_blinks_ff  <= RST_LONG_BLINKS;
         probe_blinks_ff <= RST_PROBE_BLINKS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE:     debounce_ff     <= csr_data;
            CSR_LONG_PRESS:   long_press_ff   <= csr_data;
            CSR_FLASH_ON:     flash_on_ff     <= csr_data[7:0];
            CSR_FLASH_PERIOD: flash_period_ff <= csr_data[7:0];
            CSR_SHORT_BLINKS: short_blinks_ff <= csr_data[3:0];
            CSR_LONG_BLINKS:  long_blinks_ff  <= csr_data[3:0];
            CSR_PROBE_BLINKS: probe_blinks_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      tc_in     = tc_ff;
      run_in    = run_ff;
      armed_in  = armed_ff;
      active_in = active_ff;
      phase_in  = phase_ff;
      end_in    = end_ff;
      led_in    = led_ff;
      kind_in   = KIND_NONE;
      start     = 1'b0;
      blinks    = probe_blinks_ff;

      unique case (req_tuser)
         REQ_TICK: begin
            if (run_ff) begin
               tc_in = tc_inc;
               if (armed_ff && CMP_W'(tc_inc) == CMP_W'(long_press_ff)) begin
                  armed_in = 1'b0;
                  if (pressed) begin
                     kind_in = KIND_LONG;
                     start   = 1'b1;
                     blinks  = long_blinks_ff;
                  end
               end
               // a fresh burst lies ahead of the count, so it cannot hit
               // its own deadline or end on the tick that starts it
               if (!start) begin
                  if (active_ff && tc_inc == phase_ff) begin
                     led_in   = !led_ff;
                     phase_in = tc_inc + (led_ff ? CW'(off_t) : CW'(on_t));
                  end
                  if (active_ff && tc_inc == end_ff) begin
                     tc_in     = '0;
                     run_in    = 1'b0;
                     armed_in  = 1'b0;
                     active_in = 1'b0;
                     led_in    = 1'b0;
                  end
               end
            end
         end
         REQ_BUTTON: begin
            if (tc_ff == '0) begin
               if (pressed) begin
                  armed_in = 1'b1;
                  run_in   = 1'b1;
               end
            end else if (!pressed) begin
               if (CMP_W'(tc_ff) < CMP_W'(debounce_ff)) begin
                  tc_in     = '0;
                  run_in    = 1'b0;
                  armed_in  = 1'b0;
                  active_in = 1'b0;
                  led_in    = 1'b0;
               end else if (CMP_W'(tc_ff) < CMP_W'(long_press_ff)) begin
                  armed_in = 1'b0;
                  kind_in  = KIND_SHORT;
                  start    = 1'b1;
                  blinks   = short_blinks_ff;
               end
            end
         end
         REQ_PROBE: begin
            start = 1'b1;
         end
         default: ;
      endcase

      if (start) begin
         phase_in  = tc_in + CW'(on_t);
         end_in    = tc_in + CW'(burst_span(flash_on_ff, flash_period_ff, blinks));
         led_in    = 1'b1;
         active_in = 1'b1;
         run_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff        <= '0;
         run_ff       <= 1'b0;
         armed_ff     <= 1'b0;
         active_ff    <= 1'b0;
         phase_ff     <= '0;
         end_ff       <= '0;
         led_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            tc_ff     <= tc_in;
            run_ff    <= run_in;
            armed_ff  <= armed_in;
            active_ff <= active_in;
            phase_ff  <= phase_in;
            end_ff    <= end_in;
            led_ff    <= led_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= {4'b0000, run_in, kind_in, led_in};
      end
   end

endmodule

FILE: sv/bpcb_checker.sv
// Port-level checks for the button press classifier and LED blinker.
// Depends on bpcb_pkg; bound to button_press_classifier_blinker below.
module bpcb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [7:0]                      req_tdata,
   input logic [1:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [7:0]                      rsp_tdata,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [bpcb_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [bpcb_pkg::CSR_DATA_W-1:0] csr_data
);
   import bpcb_pkg::*;

   // a result only appears after an event transfer
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without an event transfer");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // a detected press always starts a burst: LED lit and counter running
   a_press_starts_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:1] == KIND_SHORT || rsp_tdata[2:1] == KIND_LONG)
      |-> rsp_tdata[0] && rsp_tdata[3])
      else $error("press reported without burst");

   // LED is only lit while the counter runs
   a_led_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[3])
      else $error("LED lit with counter stopped");

   // an empty result register never blocks the event side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("event side stalled with no pending result");

endmodule

bind button_press_classifier_blinker bpcb_checker u_bpcb_checker (.*);

FILE: bench/button_press_classifier_blinker_test.sv
// Self-checking bench for button_press_classifier_blinker: event stream in, LED/press
// result stream out, predicted by an in-bench model of the classifier and burst timer.
// Depends on bpcb_pkg and the block itself.
`timescale 1ns / 1ps

module button_press_classifier_blinker_test;
   import bpcb_pkg::*;

   localparam int CW = 24;
   localparam logic [1:0] REQ_UNUSED = 2'd3;  // no meaning, block ignores it
   localparam int DIRECTED_SPLIT = 3;         // rows before the directed settings load
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      logic       led;
      logic [1:0] kind;
      logic       busy;
   } lamp_type;

   typedef struct packed {
      logic [1:0] code;
      logic       level;
      logic       typed;
      lamp_type   want;
   } script_row_type;

   typedef enum int {DRAIN_STEADY, DRAIN_RANDOM, DRAIN_ALTERNATE} drain_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid, req_tready;
   logic [7:0] req_tdata;
   logic [1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [7:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // settings mirror
   logic [15:0] cfg_debounce = RST_DEBOUNCE;
   logic [15:0] cfg_long     = RST_LONG_PRESS;
   logic [7:0]  cfg_on       = RST_FLASH_ON;
   logic [7:0]  cfg_period   = RST_FLASH_PERIOD;
   logic [3:0]  cfg_short_n  = RST_SHORT_BLINKS;
   logic [3:0]  cfg_long_n   = RST_LONG_BLINKS;
   logic [3:0]  cfg_probe_n  = RST_PROBE_BLINKS;

   // classifier state mirror
   logic [CW-1:0] ticks_q = '0;
   logic [CW-1:0] deadline_q = '0;
   logic [CW-1:0] burst_stop_q = '0;
   logic run_q = 1'b0;
   logic armed_q = 1'b0;
   logic flashing_q = 1'b0;
   logic lamp_q = 1'b0;

   lamp_type expected_lamp[$];
   lamp_type lamp_due;
   script_row_type directed_rows [25];
   int failures = 0;
   int items_sent = 0;
   int burst_left = 0;
   bit gappy = 1'b0;
   bit hold_off_req = 1'b0;

   button_press_classifier_blinker #(.COUNT_WIDTH(CW)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pulse_on();
      return (cfg_on == 8'd0) ? 1 : int'(cfg_on);
   endfunction

   function automatic int pulse_off();
      return (int'(cfg_period) > pulse_on()) ? int'(cfg_period) - pulse_on() : 1;
   endfunction

   function automatic void halt_all();
      ticks_q = '0;
      run_q = 1'b0;
      armed_q = 1'b0;
      flashing_q = 1'b0;
      lamp_q = 1'b0;
   endfunction

   function automatic void begin_burst(input logic [3:0] blinks);
      int n;
      n = (blinks == 4'd0) ? 1 : int'(blinks);
      deadline_q = CW'(int'(ticks_q) + pulse_on());
      burst_stop_q = CW'(int'(ticks_q) + (pulse_on() + pulse_off()) * (n - 1) + pulse_on());
      lamp_q = 1'b1;
      flashing_q = 1'b1;
      run_q = 1'b1;
   endfunction

   function automatic lamp_type predict_event(input logic [1:0] code, input logic level);
      lamp_type r;
      logic held;
      held = (level == 1'b0);
      r.kind = KIND_NONE;
      case (code)
         REQ_TICK: begin
            if (run_q) begin
               ticks_q = ticks_q + CW'(1);
               if (armed_q && ticks_q == CW'(cfg_long)) begin
                  armed_q = 1'b0;
                  if (held) begin
                     r.kind = KIND_LONG;
                     begin_burst(cfg_long_n);
                  end
               end
               if (flashing_q && ticks_q == deadline_q) begin
                  lamp_q = ~lamp_q;
                  deadline_q = CW'(int'(ticks_q) + (lamp_q ? pulse_on() : pulse_off()));
               end
               if (flashing_q && ticks_q == burst_stop_q)
                  halt_all();
            end
         end
         REQ_BUTTON: begin
            if (ticks_q == '0) begin
               if (held) begin
                  armed_q = 1'b1;
                  run_q = 1'b1;
               end
            end else if (!held) begin
               if (ticks_q < CW'(cfg_debounce)) begin
                  halt_all();
               end else if (ticks_q < CW'(cfg_long)) begin
                  armed_q = 1'b0;
                  r.kind = KIND_SHORT;
                  begin_burst(cfg_short_n);
               end
            end
         end
         REQ_PROBE: begin
            begin_burst(cfg_probe_n);
         end
         default: ;
      endcase
      r.led = lamp_q;
      r.busy = run_q;
      return r;
   endfunction

   // offer one event; valid stays up between back-to-back transfers
   task automatic offer_event(input logic [1:0] code, input logic level,
                              input logic typed, input lamp_type typed_want);
      int pause;
      lamp_type guess;
      if (gappy && burst_left == 0) begin
         pause = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0)
         burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= code;
      req_tdata <= {7'd0, level};
      do @(posedge clock); while (!req_tready);
      guess = predict_event(code, level);
      expected_lamp.push_back(typed ? typed_want : guess);
      items_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_lamp.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEBOUNCE:     cfg_debounce = value;
         CSR_LONG_PRESS:   cfg_long = value;
         CSR_FLASH_ON:     cfg_on = value[7:0];
         CSR_FLASH_PERIOD: cfg_period = value[7:0];
         CSR_SHORT_BLINKS: cfg_short_n = value[3:0];
         CSR_LONG_BLINKS:  cfg_long_n = value[3:0];
         CSR_PROBE_BLINKS: cfg_probe_n = value[3:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [15:0] debounce, input logic [15:0] long_press,
                                input logic [15:0] flash_on, input logic [15:0] period,
                                input logic [15:0] short_n, input logic [15:0] long_n,
                                input logic [15:0] probe_n);
      settle();
      csr_put(CSR_DEBOUNCE, debounce);
      csr_put(CSR_LONG_PRESS, long_press);
      csr_put(CSR_FLASH_ON, flash_on);
      csr_put(CSR_FLASH_PERIOD, period);
      csr_put(CSR_SHORT_BLINKS, short_n);
      csr_put(CSR_LONG_BLINKS, long_n);
      csr_put(CSR_PROBE_BLINKS, probe_n);
      csr_valid <= 1'b0;
   endtask

   // mostly whole presses (press, hold, release, let the burst run out), some noise
   task automatic run_phase(input int budget, input bit bursty);
      int first;
      int hold;
      int lim;
      int k;
      int n;
      first = items_sent;
      gappy = bursty;
      burst_left = 0;
      while (items_sent - first < budget) begin
         if ($urandom_range(0, 99) < 75) begin
            offer_event(REQ_BUTTON, 1'b0, 1'b0, '0);
            lim = int'(cfg_long) + 3;
            hold = $urandom_range(0, (lim > 60) ? 60 : lim);
            for (k = 0; k < hold; k++) begin
               if ($urandom_range(0, 9) == 0)
                  offer_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0, '0);
               else
                  offer_event(REQ_TICK, 1'b0, 1'b0, '0);
            end
            offer_event(REQ_BUTTON, 1'b1, 1'b0, '0);
            k = 0;
            while (run_q && k < 200) begin
               offer_event(REQ_TICK, ($urandom_range(0, 7) != 0), 1'b0, '0);
               k++;
            end
         end else begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++)
               offer_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0, '0);
         end
      end
   endtask

   // response side: steady, random or alternating readiness, plus one long hold-off
   initial begin
      drain_mode_type mode;
      int mode_left;
      int stall_left;
      rsp_tready = 1'b0;
      mode = DRAIN_STEADY;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            for (stall_left = HOLD_OFF_CYCLES; stall_left > 0; stall_left--)
               @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = drain_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         case (mode)
            DRAIN_STEADY:    rsp_tready <= 1'b1;
            DRAIN_RANDOM:    rsp_tready <= ($urandom_range(0, 3) != 0);
            DRAIN_ALTERNATE: rsp_tready <= ~rsp_tready;
            default:         rsp_tready <= 1'b1;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_lamp.size() == 0) begin
            $error("result transfer with nothing expected: rsp_tdata %h", rsp_tdata);
            failures++;
         end else begin
            lamp_due = expected_lamp.pop_front();
            if (rsp_tdata[0] !== lamp_due.led) begin
               $error("led_on: expected %0d, got %0d", lamp_due.led, rsp_tdata[0]);
               failures++;
            end
            if (rsp_tdata[2:1] !== lamp_due.kind) begin
               $error("press_kind: expected %0d, got %0d", lamp_due.kind, rsp_tdata[2:1]);
               failures++;
            end
            if (rsp_tdata[3] !== lamp_due.busy) begin
               $error("busy_res: expected %0d, got %0d", lamp_due.busy, rsp_tdata[3]);
               failures++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int i;
      int p;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_TICK;
      csr_valid = 1'b0;
      csr_index = CSR_DEBOUNCE;
      csr_data = '0;
      reset = 1'b1;

      // code, level, typed, {led, kind, busy}
      directed_rows = '{
         {REQ_TICK,   1'b1, 1'b1, 1'b0, KIND_NONE,  1'b0},  // idle after reset
         {REQ_UNUSED, 1'b0, 1'b1, 1'b0, KIND_NONE,  1'b0},
         {REQ_BUTTON, 1'b1, 1'b1, 1'b0, KIND_NONE,  1'b0},  // release while stopped
         {REQ_BUTTON, 1'b0, 1'b1, 1'b0, KIND_NONE,  1'b1},  // first press starts count
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_BUTTON, 1'b1, 1'b1, 1'b0, KIND_NONE,  1'b0},  // bounce: abort
         {REQ_BUTTON, 1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_BUTTON, 1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},  // press while counting
         {REQ_BUTTON, 1'b1, 1'b1, 1'b1, KIND_SHORT, 1'b1},  // zero blinks -> one
         {REQ_TICK,   1'b1, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_BUTTON, 1'b0, 1'b1, 1'b0, KIND_NONE,  1'b1},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b1, 1'b1, KIND_LONG,  1'b1},  // held to threshold
         {REQ_BUTTON, 1'b1, 1'b0, 1'b0, KIND_NONE,  1'b0},  // late release ignored
         {REQ_PROBE,  1'b1, 1'b1, 1'b1, KIND_NONE,  1'b1},  // restarts the burst
         {REQ_TICK,   1'b1, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_UNUSED, 1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0},
         {REQ_TICK,   1'b0, 1'b0, 1'b0, KIND_NONE,  1'b0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_SPLIT; i++)
         offer_event(directed_rows[i].code, directed_rows[i].level,
                     directed_rows[i].typed, directed_rows[i].want);
      // zero on-time, period no longer than the effective on-time, zero short blink count
      load_settings(16'd3, 16'd6, 16'd0, 16'd1, 16'd0, 16'd2, 16'd1);
      for (i = DIRECTED_SPLIT; i < $size(directed_rows); i++)
         offer_event(directed_rows[i].code, directed_rows[i].level,
                     directed_rows[i].typed, directed_rows[i].want);

      load_settings(16'd1, 16'd2, 16'd1, 16'd2, 16'd1, 16'd1, 16'd1);
      run_phase(120, 1'b1);
      load_settings(16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'd15, 16'd15, 16'd15);
      run_phase(60, 1'b0);
      load_settings(RST_DEBOUNCE, RST_LONG_PRESS, 16'(RST_FLASH_ON), 16'(RST_FLASH_PERIOD),
                    16'(RST_SHORT_BLINKS), 16'(RST_LONG_BLINKS), 16'(RST_PROBE_BLINKS));
      run_phase(80, 1'b1);
      for (p = 0; p < 7; p++) begin
         load_settings(16'($urandom_range(1, 8)), 16'($urandom_range(2, 40)),
                       16'($urandom_range(0, 6)), 16'($urandom_range(0, 12)),
                       16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                       16'($urandom_range(0, 15)));
         // keep offering while the result side holds off, so the input backs up
         if (p == 1)
            hold_off_req = 1'b1;
         run_phase(110, (p == 1) ? 1'b0 : 1'($urandom_range(0, 1)));
      end

      settle();
      repeat (5) @(posedge clock);
      if (failures == 0 && expected_lamp.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
